@@ hdl/ctip_pkg.sv @@
// Package for the calibration table interpolator.
// Holds the transaction types, the table entry type and the operation and status codes.
// No dependencies.
package ctip_pkg;

    localparam int TABLE_DEPTH_DEF = 16;

    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_LOAD  = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;
    localparam logic [1:0] KIND_SPARE = 2'd3;

    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_IGNORE = 2'd2;
    localparam logic [1:0] ST_QUERY  = 2'd3;

    typedef struct packed {
        logic [1:0]         kind;
        logic               table_sel;
        logic [15:0]        focal;
        logic [11:0]        aperture;
        logic signed [23:0] coef_a;
        logic signed [23:0] coef_b;
        logic signed [23:0] coef_c;
    } ctip_req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic               dist_valid;
        logic signed [23:0] dist_a;
        logic signed [23:0] dist_b;
        logic signed [23:0] dist_c;
        logic               vig_valid;
        logic signed [23:0] vig_k1;
        logic signed [23:0] vig_k2;
        logic signed [23:0] vig_k3;
    } ctip_rsp_t;

    typedef struct packed {
        logic [15:0]       focal;
        logic [11:0]       aperture;
        logic [2:0][23:0]  coef;
    } ctip_entry_t;

    typedef struct packed {
        logic [15:0]      x;
        logic [15:0]      lo_f;
        logic [15:0]      hi_f;
        logic [2:0][23:0] lo_c;
        logic [2:0][23:0] hi_c;
    } ctip_ireq_t;

endpackage

@@ hdl/calibration_table_interpolator.sv @@
// Calibration table interpolator, top level: two sorted entry memories and the control sequencer.
// Depends on ctip_pkg and ctip_interp.
// A query skips an empty table and leaves its valid flag clear.
// One transaction is in work at a time. Reset empties both tables at once; no clearing pass.
module calibration_table_interpolator #(
    parameter int TABLE_DEPTH = ctip_pkg::TABLE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  ctip_pkg::ctip_req_t req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output ctip_pkg::ctip_rsp_t rsp
);
    import ctip_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_DEPTH);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_INS      = 3'd1;
    localparam logic [2:0] S_INS_CMP  = 3'd2;
    localparam logic [2:0] S_SCAN     = 3'd3;
    localparam logic [2:0] S_SCAN_END = 3'd4;
    localparam logic [2:0] S_IWAIT    = 3'd5;
    localparam logic [2:0] S_VIG      = 3'd6;
    localparam logic [2:0] S_FIN      = 3'd7;

    logic [2:0]    state_reg, state_next;
    ctip_req_t     cmd_reg, cmd_next;
    logic [CW-1:0] dcnt_reg, dcnt_next;
    logic [CW-1:0] vcnt_reg, vcnt_next;
    logic [AW-1:0] ins_pos_reg, ins_pos_next;
    logic          tsel_reg, tsel_next;
    logic          aper_reg, aper_next;
    logic [CW-1:0] iss_reg, iss_next;
    logic          pend_reg, pend_next;
    logic          have_reg, have_next;
    logic          found_reg, found_next;
    logic          multi_reg, multi_next;
    logic [11:0]   best_reg, best_next;
    logic [11:0]   bd_reg, bd_next;
    ctip_entry_t   first_reg, first_next;
    ctip_entry_t   prev_reg, prev_next;
    ctip_entry_t   lo_reg, lo_next;
    ctip_entry_t   hi_reg, hi_next;
    ctip_rsp_t     res_reg, res_next;
    ctip_rsp_t     rsp_reg, rsp_next;
    logic          rsp_valid_reg, rsp_valid_next;

    ctip_entry_t dmem [TABLE_DEPTH];
    ctip_entry_t vmem [TABLE_DEPTH];
    ctip_entry_t drdata_reg, vrdata_reg;

    logic          d_we, v_we;
    logic [AW-1:0] waddr, raddr;
    ctip_entry_t   wdata, new_entry, rd, e;
    logic [CW-1:0] cnt_cur;
    logic [11:0]   ap_dist;
    logic          fill_en;
    logic [2:0][23:0] fill_coef;

    ctip_ireq_t       ireq;
    logic             istart, idone;
    logic [2:0][23:0] icoef;

    assign new_entry.focal    = cmd_reg.focal;
    assign new_entry.aperture = cmd_reg.aperture;
    assign new_entry.coef[0]  = cmd_reg.coef_a;
    assign new_entry.coef[1]  = cmd_reg.coef_b;
    assign new_entry.coef[2]  = cmd_reg.coef_c;

    assign rd      = cmd_reg.table_sel ? vrdata_reg : drdata_reg;
    assign e       = tsel_reg ? vrdata_reg : drdata_reg;
    assign cnt_cur = tsel_reg ? vcnt_reg : dcnt_reg;
    assign ap_dist = (e.aperture >= cmd_reg.aperture) ? e.aperture - cmd_reg.aperture
                                                      : cmd_reg.aperture - e.aperture;

    assign ireq.x    = cmd_reg.focal;
    assign ireq.lo_f = lo_reg.focal;
    assign ireq.hi_f = hi_reg.focal;
    assign ireq.lo_c = lo_reg.coef;
    assign ireq.hi_c = hi_reg.coef;

    ctip_interp u_interp (
        .clk   (clk),
        .rst_n (rst_n),
        .start (istart),
        .ireq  (ireq),
        .done  (idone),
        .coef  (icoef)
    );

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        dcnt_next      = dcnt_reg;
        vcnt_next      = vcnt_reg;
        ins_pos_next   = ins_pos_reg;
        tsel_next      = tsel_reg;
        aper_next      = aper_reg;
        iss_next       = iss_reg;
        pend_next      = pend_reg;
        have_next      = have_reg;
        found_next     = found_reg;
        multi_next     = multi_reg;
        best_next      = best_reg;
        bd_next        = bd_reg;
        first_next     = first_reg;
        prev_next      = prev_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        d_we           = 1'b0;
        v_we           = 1'b0;
        waddr          = ins_pos_reg;
        wdata          = new_entry;
        raddr          = '0;
        istart         = 1'b0;
        fill_en        = 1'b0;
        fill_coef      = first_reg.coef;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd_next = req;
                    res_next = '0;
                    res_next.status = ST_DONE;
                    state_next = S_FIN;
                    case (req.kind)
                        KIND_CLEAR:
                        begin
                            dcnt_next = '0;
                            vcnt_next = '0;
                        end
                        KIND_LOAD:
                        begin
                            if (req.focal == 16'd0)
                            begin
                                res_next.status = ST_IGNORE;
                            end
                            else if ((req.table_sel ? vcnt_reg : dcnt_reg) == FULL_CNT)
                            begin
                                res_next.status = ST_FULL;
                            end
                            else
                            begin
                                ins_pos_next = AW'(req.table_sel ? vcnt_reg : dcnt_reg);
                                state_next   = S_INS;
                            end
                        end
                        KIND_QUERY:
                        begin
                            res_next.status = ST_QUERY;
                            if (dcnt_reg != '0)
                            begin
                                tsel_next  = 1'b0;
                                aper_next  = 1'b0;
                                iss_next   = '0;
                                pend_next  = 1'b0;
                                have_next  = 1'b0;
                                found_next = 1'b0;
                                multi_next = 1'b0;
                                state_next = S_SCAN;
                            end
                            else
                            begin
                                state_next = S_VIG;
                            end
                        end
                        default: state_next = S_FIN;
                    endcase
                end
            end
            S_INS:
            begin
                if (ins_pos_reg == '0)
                begin
                    d_we = !cmd_reg.table_sel;
                    v_we = cmd_reg.table_sel;
                    if (cmd_reg.table_sel)
                        vcnt_next = vcnt_reg + 1'b1;
                    else
                        dcnt_next = dcnt_reg + 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    raddr      = ins_pos_reg - 1'b1;
                    state_next = S_INS_CMP;
                end
            end
            S_INS_CMP:
            begin
                d_we = !cmd_reg.table_sel;
                v_we = cmd_reg.table_sel;
                if (rd.focal > cmd_reg.focal)
                begin
                    wdata        = rd;
                    ins_pos_next = ins_pos_reg - 1'b1;
                    state_next   = S_INS;
                end
                else
                begin
                    if (cmd_reg.table_sel)
                        vcnt_next = vcnt_reg + 1'b1;
                    else
                        dcnt_next = dcnt_reg + 1'b1;
                    state_next = S_FIN;
                end
            end
            S_SCAN:
            begin
                if (iss_reg < cnt_cur)
                begin
                    raddr     = iss_reg[AW-1:0];
                    iss_next  = iss_reg + 1'b1;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                        state_next = S_SCAN_END;
                end
                if (pend_reg)
                begin
                    if (aper_reg)
                    begin
                        if (!have_reg || ap_dist < bd_reg)
                        begin
                            bd_next   = ap_dist;
                            best_next = e.aperture;
                            have_next = 1'b1;
                        end
                    end
                    else if (!tsel_reg || e.aperture == best_reg)
                    begin
                        if (!have_reg)
                        begin
                            first_next = e;
                            have_next  = 1'b1;
                        end
                        else
                        begin
                            multi_next = 1'b1;
                            if (!found_reg && cmd_reg.focal <= e.focal)
                            begin
                                lo_next    = prev_reg;
                                hi_next    = e;
                                found_next = 1'b1;
                            end
                        end
                        prev_next = e;
                    end
                end
            end
            S_SCAN_END:
            begin
                if (aper_reg)
                begin
                    aper_next  = 1'b0;
                    iss_next   = '0;
                    pend_next  = 1'b0;
                    have_next  = 1'b0;
                    found_next = 1'b0;
                    multi_next = 1'b0;
                    state_next = S_SCAN;
                end
                else if (!multi_reg || cmd_reg.focal <= first_reg.focal)
                begin
                    fill_en   = 1'b1;
                    fill_coef = first_reg.coef;
                end
                else if (cmd_reg.focal >= prev_reg.focal)
                begin
                    fill_en   = 1'b1;
                    fill_coef = prev_reg.coef;
                end
                else
                begin
                    istart     = 1'b1;
                    state_next = S_IWAIT;
                end
            end
            S_IWAIT:
            begin
                if (idone)
                begin
                    fill_en   = 1'b1;
                    fill_coef = icoef;
                end
            end
            S_VIG:
            begin
                if (vcnt_reg != '0)
                begin
                    tsel_next  = 1'b1;
                    aper_next  = 1'b1;
                    iss_next   = '0;
                    pend_next  = 1'b0;
                    have_next  = 1'b0;
                    found_next = 1'b0;
                    multi_next = 1'b0;
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (fill_en)
        begin
            if (tsel_reg)
            begin
                res_next.vig_valid = 1'b1;
                res_next.vig_k1    = fill_coef[0];
                res_next.vig_k2    = fill_coef[1];
                res_next.vig_k3    = fill_coef[2];
                state_next         = S_FIN;
            end
            else
            begin
                res_next.dist_valid = 1'b1;
                res_next.dist_a     = fill_coef[0];
                res_next.dist_b     = fill_coef[1];
                res_next.dist_c     = fill_coef[2];
                state_next          = S_VIG;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (d_we)
            dmem[waddr] <= wdata;
        if (v_we)
            vmem[waddr] <= wdata;
        drdata_reg <= dmem[raddr];
        vrdata_reg <= vmem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            dcnt_reg      <= '0;
            vcnt_reg      <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            dcnt_reg      <= dcnt_next;
            vcnt_reg      <= vcnt_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        ins_pos_reg <= ins_pos_next;
        tsel_reg    <= tsel_next;
        aper_reg    <= aper_next;
        iss_reg     <= iss_next;
        have_reg    <= have_next;
        found_reg   <= found_next;
        multi_reg   <= multi_next;
        best_reg    <= best_next;
        bd_reg      <= bd_next;
        first_reg   <= first_next;
        prev_reg    <= prev_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        res_reg     <= res_next;
        rsp_reg     <= rsp_next;
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (dcnt_reg <= FULL_CNT) && (vcnt_reg <= FULL_CNT))
        else $error("table count exceeds depth");

    a_interp_done: assert property (@(posedge clk) disable iff (!rst_n)
        idone |-> (state_reg == S_IWAIT))
        else $error("interpolation finished outside its wait state");

    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        (d_we || v_we) |-> (state_reg == S_INS || state_reg == S_INS_CMP))
        else $error("table write outside an insertion");

    a_flags_query: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status != ST_QUERY) |-> (!rsp.dist_valid && !rsp.vig_valid))
        else $error("valid flag set on a non-query transaction");

endmodule

@@ hdl/ctip_interp.sv @@
// Interpolation unit: a restoring divider for the Q1.16 weight and one shared multiplier.
// Depends on ctip_pkg.
module ctip_interp (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  ctip_pkg::ctip_ireq_t ireq,
    output logic                done,
    output logic [2:0][23:0]    coef
);
    import ctip_pkg::*;

    localparam logic [1:0] I_IDLE = 2'd0;
    localparam logic [1:0] I_DIV  = 2'd1;
    localparam logic [1:0] I_MUL  = 2'd2;
    localparam logic [1:0] I_ADD  = 2'd3;

    logic [1:0]         st_reg, st_next;
    ctip_ireq_t         req_reg, req_next;
    logic [15:0]        rem_reg, rem_next;
    logic [16:0]        q_reg, q_next;
    logic [3:0]         cnt_reg, cnt_next;
    logic [1:0]         j_reg, j_next;
    logic signed [41:0] prod_reg, prod_next;
    logic [2:0][23:0]   out_reg, out_next;
    logic               done_reg, done_next;

    logic [16:0]        shifted;
    logic signed [24:0] diff;
    logic signed [24:0] sum;

    assign shifted = {rem_reg, 1'b0};
    assign diff = $signed({req_reg.hi_c[j_reg][23], req_reg.hi_c[j_reg]})
                - $signed({req_reg.lo_c[j_reg][23], req_reg.lo_c[j_reg]});
    assign sum = $signed({req_reg.lo_c[j_reg][23], req_reg.lo_c[j_reg]})
               + $signed(prod_reg[40:16]);

    always_comb
    begin
        st_next   = st_reg;
        req_next  = req_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        j_next    = j_reg;
        prod_next = prod_reg;
        out_next  = out_reg;
        done_next = 1'b0;
        unique case (st_reg)
            I_IDLE:
            begin
                if (start)
                begin
                    req_next = ireq;
                    if (ireq.x == ireq.hi_f)
                    begin
                        rem_next = '0;
                        q_next   = 17'd1;
                    end
                    else
                    begin
                        rem_next = ireq.x - ireq.lo_f;
                        q_next   = '0;
                    end
                    cnt_next = '0;
                    st_next  = I_DIV;
                end
            end
            I_DIV:
            begin
                if (shifted >= {1'b0, req_reg.hi_f - req_reg.lo_f})
                begin
                    rem_next = 16'(shifted - {1'b0, req_reg.hi_f - req_reg.lo_f});
                    q_next   = {q_reg[15:0], 1'b1};
                end
                else
                begin
                    rem_next = shifted[15:0];
                    q_next   = {q_reg[15:0], 1'b0};
                end
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                begin
                    j_next  = '0;
                    st_next = I_MUL;
                end
            end
            I_MUL:
            begin
                prod_next = 42'($signed({1'b0, q_reg}) * diff);
                st_next   = I_ADD;
            end
            I_ADD:
            begin
                out_next[j_reg] = sum[23:0];
                if (j_reg == 2'd2)
                begin
                    done_next = 1'b1;
                    st_next   = I_IDLE;
                end
                else
                begin
                    j_next  = j_reg + 2'd1;
                    st_next = I_MUL;
                end
            end
            default: st_next = I_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= I_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        cnt_reg  <= cnt_next;
        j_reg    <= j_next;
        prod_reg <= prod_next;
        out_reg  <= out_next;
    end

    assign done = done_reg;
    assign coef = out_reg;

endmodule
